>>> src/kps_pkg.sv
// ----------------------------------------------------------------------------
// kps_pkg
// Shared types, codes and helpers for the key status and fast interrupt block.
// ----------------------------------------------------------------------------
package kps_pkg;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_ROW   = 2'd2,
		ACT_IRQ   = 2'd3
	} action_t;

	localparam logic [3:0] OFS_STATUS  = 4'd1;
	localparam logic [3:0] OFS_ROW_SEL = 4'd2;
	localparam logic [3:0] OFS_ACK     = 4'd4;
	localparam logic [3:0] OFS_MASK    = 4'd5;

	localparam logic [3:0] ROW_ALL = 4'hf;

	localparam logic [1:0] SRC_LINK_TX = 2'd0;
	localparam logic [1:0] SRC_RX0     = 2'd1;
	localparam logic [1:0] SRC_RX1     = 2'd2;
	localparam logic [1:0] SRC_MIDI_TX = 2'd3;

	typedef struct packed {
		action_t    action;
		logic [3:0] reg_offset;
		logic [7:0] write_data;
		logic [3:0] row_index;
		logic [7:0] row_value;
		logic [1:0] irq_source;
		logic       irq_level;
	} item_t;

	typedef struct packed {
		logic  commit;
		item_t item;
	} cmd_t;

	typedef struct packed {
		logic       ready;
		logic [2:0] key_idx;
	} key_stat_t;

	typedef struct packed {
		logic [3:0] pending;
		logic       firq_next;
		logic       rx_sel_next;
	} irq_stat_t;

	function automatic logic [2:0] msb_index(input logic [7:0] v);
		logic [2:0] idx;
		idx = 3'd0;
		for (int b = 0; b < 8; b++) begin
			if (v[b]) begin
				idx = 3'(b);
			end
		end
		return idx;
	endfunction

endpackage

>>> src/kps_key_bank.sv
// ----------------------------------------------------------------------------
// kps_key_bank
// Key matrix rows, row select register and key priority encoding.
// ----------------------------------------------------------------------------
module kps_key_bank import kps_pkg::*; #(
	parameter int KEY_ROWS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output key_stat_t stat
);

	localparam int IW = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
	localparam logic [3:0] ROWS4 = 4'(KEY_ROWS);

	logic [7:0] rows_q [KEY_ROWS];
	logic [3:0] row_sel_q;
	logic [7:0] all_or;
	logic [7:0] sel_row;
	logic [7:0] keys;
	logic       in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < KEY_ROWS; r++) begin
				rows_q[r] <= 8'h00;
			end
			row_sel_q <= 4'd0;
		end else if (cmd.commit) begin
			if (cmd.item.action == ACT_ROW && cmd.item.row_index < ROWS4) begin
				rows_q[cmd.item.row_index[IW-1:0]] <= cmd.item.row_value;
			end
			if (cmd.item.action == ACT_WRITE && cmd.item.reg_offset == OFS_ROW_SEL) begin
				row_sel_q <= cmd.item.write_data[6:3];
			end
		end
	end

	always_comb begin
		all_or = 8'h00;
		for (int r = 0; r < KEY_ROWS; r++) begin
			all_or = all_or | rows_q[r];
		end
	end

	assign in_range = row_sel_q < ROWS4;
	assign sel_row  = in_range ? rows_q[row_sel_q[IW-1:0]] : 8'h00;
	assign keys     = (row_sel_q == ROW_ALL) ? all_or : sel_row;

	assign stat.ready   = (row_sel_q != ROW_ALL) ^ (|keys);
	assign stat.key_idx = msb_index(keys);

endmodule

>>> src/kps_irq_regs.sv
// ----------------------------------------------------------------------------
// kps_irq_regs
// Config select bit, pending fast interrupt bits and interrupt mask.
// ----------------------------------------------------------------------------
module kps_irq_regs import kps_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output irq_stat_t stat
);

	logic [3:0] pend_q;
	logic [3:0] mask_q;
	logic       rx_sel_q;
	logic [3:0] pend_d;
	logic [3:0] mask_d;
	logic       rx_sel_d;

	always_comb begin
		pend_d   = pend_q;
		mask_d   = mask_q;
		rx_sel_d = rx_sel_q;
		if (cmd.commit) begin
			case (cmd.item.action)
				ACT_WRITE: begin
					if (cmd.item.reg_offset == OFS_STATUS) begin
						rx_sel_d = cmd.item.write_data[0];
					end else if (cmd.item.reg_offset == OFS_ACK) begin
						pend_d = pend_q & ~cmd.item.write_data[6:3];
					end else if (cmd.item.reg_offset == OFS_MASK) begin
						mask_d = cmd.item.write_data[6:3];
					end
				end
				ACT_IRQ: begin
					if (cmd.item.irq_level) begin
						case (cmd.item.irq_source)
							SRC_LINK_TX: pend_d[0] = 1'b1;
							SRC_RX0:     if (!rx_sel_q) pend_d[1] = 1'b1;
							SRC_RX1:     if (rx_sel_q) pend_d[1] = 1'b1;
							SRC_MIDI_TX: pend_d[3] = 1'b1;
							default:     pend_d = pend_q;
						endcase
					end
				end
				default: pend_d = pend_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= 4'd0;
			mask_q   <= 4'd0;
			rx_sel_q <= 1'b0;
		end else begin
			pend_q   <= pend_d;
			mask_q   <= mask_d;
			rx_sel_q <= rx_sel_d;
		end
	end

	assign stat.pending     = pend_q;
	assign stat.firq_next   = |(pend_d & ~mask_d);
	assign stat.rx_sel_next = rx_sel_d;

endmodule

>>> src/keypad_status_and_fast_irq_regs_unit.sv
// ----------------------------------------------------------------------------
// keypad_status_and_fast_irq_regs_unit
// Key matrix status and fast interrupt register block.
//
//  channel  valid         stall         payload
//  item     item_valid    item_stall    action reg_offset write_data row_index
//                                       row_value irq_source irq_level
//  result   result_valid  result_stall  read_data firq_line rx_uart_select
//
// One beat per cycle while no result stalls. The input register takes the
// item and feeds the decode and register update; the output register then
// holds the result, valid from there until it is taken.
// Reset clears all key rows, row select, config, pending bits and mask.
// A stalled result holds the item stage; item_stall rises only then.
// ----------------------------------------------------------------------------
module keypad_status_and_fast_irq_regs_unit import kps_pkg::*; #(
	parameter int KEY_ROWS = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] action,
	input  logic [3:0] reg_offset,
	input  logic [7:0] write_data,
	input  logic [3:0] row_index,
	input  logic [7:0] row_value,
	input  logic [1:0] irq_source,
	input  logic       irq_level,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] read_data,
	output logic       firq_line,
	output logic       rx_uart_select
);

	logic      valid_s1;
	item_t     item_s1;
	logic      result_valid_q;
	logic [7:0] read_data_q;
	logic      firq_q;
	logic      rx_sel_q;
	logic      adv;
	cmd_t      cmd;
	key_stat_t key_stat;
	irq_stat_t irq_stat;
	logic [7:0] rdata;

	assign adv        = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !adv;
	assign cmd.commit = valid_s1 && adv;
	assign cmd.item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= '{action: action_t'(action), reg_offset: reg_offset,
				write_data: write_data, row_index: row_index, row_value: row_value,
				irq_source: irq_source, irq_level: irq_level};
		end
	end

	kps_key_bank #(
		.KEY_ROWS(KEY_ROWS)
	) u_key_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (key_stat)
	);

	kps_irq_regs u_irq_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (irq_stat)
	);

	assign rdata = (item_s1.action == ACT_READ && item_s1.reg_offset == OFS_STATUS)
		? {key_stat.ready, irq_stat.pending, key_stat.key_idx} : 8'h00;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			read_data_q <= rdata;
			firq_q      <= irq_stat.firq_next;
			rx_sel_q    <= irq_stat.rx_sel_next;
		end
	end

	assign result_valid   = result_valid_q;
	assign read_data      = read_data_q;
	assign firq_line      = firq_q;
	assign rx_uart_select = rx_sel_q;

endmodule
